// ----- hw/rtl/pai_pkg.sv -----
// ----------------------------------------------------------------------------
// pai_pkg
// Shared types and constants for the PID controller with an asymmetric
// integral accumulator.
// ----------------------------------------------------------------------------
package pai_pkg;

  // Datapath and register widths.
  localparam int DATA_W    = 16;
  localparam int GAIN_W    = 10;
  localparam int CFG_IDX_W = 3;

  // Fixed guard limit for the integral steps.
  localparam logic signed [DATA_W-1:0] INTEG_LIMIT = 16'sd2047;

  // Register reset values.
  localparam logic [GAIN_W-1:0]        PROP_GAIN_RST  = 10'd10;
  localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST = 10'd1;
  localparam logic [GAIN_W-1:0]        DERIV_GAIN_RST = 10'd2;
  localparam logic signed [DATA_W-1:0] OUT_MIN_RST    = 16'sd0;
  localparam logic signed [DATA_W-1:0] OUT_MAX_RST    = 16'sd2047;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_OUT_MIN    = 3'd3,
    REG_OUT_MAX    = 3'd4
  } cfg_idx_e;

  // One input item.
  typedef struct packed {
    logic signed [DATA_W-1:0] target;
    logic signed [DATA_W-1:0] measured;
  } sample_t;

  // One result item.
  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] integ_term;
    logic signed [DATA_W-1:0] err_now;
  } result_t;

  // Configuration register set.
  typedef struct packed {
    logic [GAIN_W-1:0]        prop_gain;
    logic [GAIN_W-1:0]        integ_gain;
    logic [GAIN_W-1:0]        deriv_gain;
    logic signed [DATA_W-1:0] out_min;
    logic signed [DATA_W-1:0] out_max;
  } cfg_regs_t;

  // Controller state carried from one sample to the next.
  typedef struct packed {
    logic signed [DATA_W-1:0] prev_err;
    logic signed [DATA_W-1:0] integ_acc;
  } ctrl_state_t;

endpackage

// ----- hw/rtl/pai_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pai_cfg_regs
// Configuration register file: gains and clamp limits, written by index.
// ----------------------------------------------------------------------------
module pai_cfg_regs import pai_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] index,
  input  logic [DATA_W-1:0]    wdata,
  output cfg_regs_t            cfg
);

  // Register writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain  <= PROP_GAIN_RST;
      cfg.integ_gain <= INTEG_GAIN_RST;
      cfg.deriv_gain <= DERIV_GAIN_RST;
      cfg.out_min    <= OUT_MIN_RST;
      cfg.out_max    <= OUT_MAX_RST;
    end else if (wr_en) begin
      unique case (cfg_idx_e'(index))
        REG_PROP_GAIN:  cfg.prop_gain  <= wdata[GAIN_W-1:0];
        REG_INTEG_GAIN: cfg.integ_gain <= wdata[GAIN_W-1:0];
        REG_DERIV_GAIN: cfg.deriv_gain <= wdata[GAIN_W-1:0];
        REG_OUT_MIN:    cfg.out_min    <= $signed(wdata);
        REG_OUT_MAX:    cfg.out_max    <= $signed(wdata);
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/pai_datapath.sv -----
// ----------------------------------------------------------------------------
// pai_datapath
// Single-pass PID arithmetic: error, proportional and derivative terms, the
// asymmetric integral step with its guards, and both clamps.
// ----------------------------------------------------------------------------
module pai_datapath import pai_pkg::*; (
  input  cfg_regs_t   cfg,
  input  sample_t     sample,
  input  ctrl_state_t state,
  output result_t     result,
  output ctrl_state_t state_next
);

  localparam logic signed [DATA_W-1:0] ZERO = '0;

  // Signed value times an unsigned gain, wrapped to the data width.
  function automatic logic signed [DATA_W-1:0] mul_wrap(
    input logic signed [DATA_W-1:0] a,
    input logic [GAIN_W-1:0]        g
  );
    logic signed [DATA_W+GAIN_W:0] p;
    p = a * $signed({1'b0, g});
    return p[DATA_W-1:0];
  endfunction

  // Division by a power of two, truncating toward zero.
  function automatic logic signed [DATA_W-1:0] div_trunc(
    input logic signed [DATA_W-1:0] v,
    input int                       sh
  );
    logic signed [DATA_W:0] x;
    logic signed [DATA_W:0] bias;
    logic signed [DATA_W:0] q;
    x    = {v[DATA_W-1], v};
    bias = (DATA_W+1)'((1 << sh) - 1);
    if (v[DATA_W-1]) begin
      x = x + bias;
    end
    q = x >>> sh;
    return q[DATA_W-1:0];
  endfunction

  // Raise to the lower limit first, then lower to the upper limit.
  function automatic logic signed [DATA_W-1:0] clamp(
    input logic signed [DATA_W-1:0] v,
    input logic signed [DATA_W-1:0] lo,
    input logic signed [DATA_W-1:0] hi
  );
    logic signed [DATA_W-1:0] r;
    r = v;
    if (r < lo) begin
      r = lo;
    end
    if (r > hi) begin
      r = hi;
    end
    return r;
  endfunction

  logic signed [DATA_W-1:0] err;
  logic signed [DATA_W-1:0] err_diff;
  logic signed [DATA_W-1:0] pterm;
  logic signed [DATA_W-1:0] iprod;
  logic signed [DATA_W-1:0] dterm;
  logic signed [DATA_W-1:0] acc_step;
  logic signed [DATA_W-1:0] acc_clamped;
  logic signed [DATA_W-1:0] sum;

  // Error, its change, and the three gain products.
  assign err      = sample.target - sample.measured;
  assign err_diff = err - state.prev_err;
  assign pterm    = mul_wrap(err, cfg.prop_gain);
  assign iprod    = mul_wrap(err, cfg.integ_gain);
  assign dterm    = mul_wrap(err_diff, cfg.deriv_gain);

  // Integral step chosen by the error's sign and its trend.
  always_comb begin
    acc_step = state.integ_acc;
    if (!err[DATA_W-1]) begin
      if (err >= state.prev_err) begin
        if (state.integ_acc < INTEG_LIMIT) begin
          acc_step = state.integ_acc + div_trunc(iprod, 2);
        end
      end else if (state.integ_acc > ZERO) begin
        acc_step = state.integ_acc - div_trunc(iprod, 3);
      end
    end else begin
      if (err > state.prev_err) begin
        if (state.integ_acc < INTEG_LIMIT) begin
          acc_step = state.integ_acc - div_trunc(iprod, 4);
        end
      end else if (state.integ_acc > ZERO) begin
        acc_step = state.integ_acc + div_trunc(iprod, 1);
      end
    end
  end

  assign acc_clamped = clamp(acc_step, cfg.out_min, cfg.out_max);

  // Output sum of the three terms, clamped.
  assign sum = pterm + acc_clamped + dterm;

  assign result.drive      = clamp(sum, cfg.out_min, cfg.out_max);
  assign result.integ_term = acc_clamped;
  assign result.err_now    = err;

  assign state_next.prev_err  = err;
  assign state_next.integ_acc = acc_clamped;

endmodule

// ----- hw/rtl/pid_asymmetric_integral.sv -----
// ----------------------------------------------------------------------------
// pid_asymmetric_integral
// PID controller whose integral accumulator steps by different fractions of
// Ki*e depending on the error's sign and trend, with clamped output.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                      Payload
//   sample    in         sample_valid / sample_stall    sample_t (target, measured)
//   result    out        result_valid / result_stall    result_t (drive, integ_term, err_now)
//   cfg       in         cfg_wr_en                      cfg_index, cfg_wdata
//
// An accepted sample is loaded into the input register, and its result into the
// result register when the pipeline advances, which a result-side stall can delay. One
// sample is taken every cycle while the result side does not stall; the limit is the
// integral accumulator loop, which closes through the controller state register.
// Synchronous reset clears the pipeline valids, the error history and the
// accumulator, and loads the register defaults. A stall on the result side
// holds the result register and backs up into the input register.
// ----------------------------------------------------------------------------
module pid_asymmetric_integral import pai_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  sample_t              sample,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  cfg_regs_t   cfg;
  logic        s1_valid;
  sample_t     s1_sample;
  ctrl_state_t state;
  ctrl_state_t state_next;
  result_t     result_next;
  logic        advance;

  pai_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  pai_datapath u_datapath (
    .cfg        (cfg),
    .sample     (s1_sample),
    .state      (state),
    .result     (result_next),
    .state_next (state_next)
  );

  // Pipeline flow control.
  assign advance      = s1_valid && (!result_valid || !result_stall);
  assign sample_stall = s1_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!sample_stall) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!sample_stall && sample_valid) begin
      s1_sample <= sample;
    end
  end

  // Result register and controller state, updated together.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      state        <= '0;
    end else begin
      if (advance) begin
        result_valid <= 1'b1;
        state        <= state_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // The held result always reflects the current controller state.
  a_acc_matches : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.integ_term == state.integ_acc)
    else $error("integral state differs from the held result");

  a_err_matches : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.err_now == state.prev_err)
    else $error("error history differs from the held result");

  // With sane limits the output stays inside them.
  a_drive_range : assert property (@(posedge clk) disable iff (rst)
    (result_valid && cfg.out_min <= cfg.out_max) |->
      (result.drive >= cfg.out_min && result.drive <= cfg.out_max))
    else $error("drive outside the clamp limits");

  // An empty input register never pushes back.
  a_stall_only_full : assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !sample_stall)
    else $error("input stalled with an empty input register");

endmodule

// ----- bench/pid_drive_checker.sv -----
// ----------------------------------------------------------------------------
// pid_drive_checker
// Watches the sample, result and register write ports of the asymmetric
// integral PID block. It keeps its own copy of the gains, the clamp limits
// and the loop state, predicts the result of every accepted sample, and
// compares each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module pid_drive_checker import pai_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  input  logic                 sample_stall,
  input  sample_t              sample,
  input  logic                 result_valid,
  input  logic                 result_stall,
  input  result_t              result,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_regs_t   gains_cfg;
  ctrl_state_t loop_state;
  result_t     expected_drives[$];
  int          mismatches = 0;

  // Raise to the lower limit first, then lower to the upper limit, so an
  // inverted pair of limits yields the upper one.
  function automatic logic signed [DATA_W-1:0] clamp_limits(
      logic signed [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    lo = gains_cfg.out_min;
    hi = gains_cfg.out_max;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  // Computes the result of one sample and advances the loop state.
  function automatic result_t predict_drive(sample_t s);
    logic signed [DATA_W-1:0] err;
    logic signed [DATA_W-1:0] prev;
    logic signed [DATA_W-1:0] acc;
    logic signed [DATA_W-1:0] prod;
    logic signed [DATA_W-1:0] pterm;
    logic signed [DATA_W-1:0] delta;
    logic signed [DATA_W-1:0] dterm;
    logic signed [DATA_W-1:0] sum;
    result_t r;
    prev  = loop_state.prev_err;
    acc   = loop_state.integ_acc;
    err   = s.target - s.measured;
    pterm = DATA_W'(int'(err) * int'(gains_cfg.prop_gain));
    prod  = DATA_W'(int'(err) * int'(gains_cfg.integ_gain));

    // The step size depends on the error's sign and on its trend; each step
    // is skipped when the accumulator sits on the matching fixed guard.
    if (err >= 0) begin
      if (err >= prev) begin
        if (acc < INTEG_LIMIT) acc = DATA_W'(int'(acc) + int'(prod) / 4);
      end else begin
        if (acc > 0) acc = DATA_W'(int'(acc) - int'(prod) / 8);
      end
    end else begin
      if (err > prev) begin
        if (acc < INTEG_LIMIT) acc = DATA_W'(int'(acc) - int'(prod) / 16);
      end else begin
        if (acc > 0) acc = DATA_W'(int'(acc) + int'(prod) / 2);
      end
    end
    acc = clamp_limits(acc);

    delta = err - prev;
    dterm = DATA_W'(int'(delta) * int'(gains_cfg.deriv_gain));
    sum   = pterm + acc + dterm;

    loop_state.prev_err  = err;
    loop_state.integ_acc = acc;
    r.drive      = clamp_limits(sum);
    r.integ_term = acc;
    r.err_now    = err;
    return r;
  endfunction

  task automatic check_field(string name, logic [DATA_W-1:0] want,
                             logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  // All channels are sampled at the rising edge; register writes land first,
  // then the accepted sample is predicted, then the accepted result checked.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      gains_cfg.prop_gain  = PROP_GAIN_RST;
      gains_cfg.integ_gain = INTEG_GAIN_RST;
      gains_cfg.deriv_gain = DERIV_GAIN_RST;
      gains_cfg.out_min    = OUT_MIN_RST;
      gains_cfg.out_max    = OUT_MAX_RST;
      loop_state           = '0;
      expected_drives.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PROP_GAIN:  gains_cfg.prop_gain  = cfg_wdata[GAIN_W-1:0];
          REG_INTEG_GAIN: gains_cfg.integ_gain = cfg_wdata[GAIN_W-1:0];
          REG_DERIV_GAIN: gains_cfg.deriv_gain = cfg_wdata[GAIN_W-1:0];
          REG_OUT_MIN:    gains_cfg.out_min    = cfg_wdata;
          REG_OUT_MAX:    gains_cfg.out_max    = cfg_wdata;
          default: ;
        endcase
      end
      if (sample_valid && !sample_stall) begin
        expected_drives.push_back(predict_drive(sample));
      end
      if (result_valid && !result_stall) begin
        if (expected_drives.size() == 0) begin
          $error("result item arrived with no prediction waiting");
          mismatches++;
        end else begin
          want = expected_drives.pop_front();
          check_field("drive", want.drive, result.drive);
          check_field("integ_term", want.integ_term, result.integ_term);
          check_field("err_now", want.err_now, result.err_now);
        end
      end
    end
    pending    <= expected_drives.size();
    fail_count <= mismatches;
  end

endmodule

// ----- bench/pid_asymmetric_integral_tb.sv -----
// ----------------------------------------------------------------------------
// pid_asymmetric_integral_tb
// Drives the asymmetric integral PID block with a directed run through the
// four integral steps, their guards and the field extremes, then with random
// samples under several register settings and idling patterns, including a
// long receiver hold-off that backs the block up. A checker module beside
// the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module pid_asymmetric_integral_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pai_pkg::*;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int DRAIN_CYCLES     = 6;
  localparam int HOLD_LEN         = 60;
  localparam int RANDOM_PHASES    = 8;
  localparam int RANDOM_PER_PHASE = 60;
  localparam int PRESSURE_ITEMS   = 48;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_stall;
  sample_t              sample = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_PROP_GAIN;
  logic [DATA_W-1:0]    cfg_wdata = '0;

  int fail_count;
  int pending;
  int cycle_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  logic signed [DATA_W-1:0] drift_point = '0;

  pid_asymmetric_integral dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  pid_drive_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always #1 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      result_stall <= 1'b1;
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic sample_t pt(int tgt, int meas);
    sample_t s;
    s.target   = DATA_W'(tgt);
    s.measured = DATA_W'(meas);
    return s;
  endfunction

  function automatic logic signed [DATA_W-1:0] corner_value();
    case ($urandom_range(3))
      0:       return 16'sh8000;
      1:       return -16'sd1;
      2:       return 16'sd0;
      default: return 16'sh7fff;
    endcase
  endfunction

  // In 45 of 100 items a slowly drifting setpoint with a small error, so the integral
  // steps and their trends interleave; 15 are corners and the rest raw noise.
  function automatic sample_t random_sample();
    sample_t s;
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      drift_point = DATA_W'(drift_point + (int'($urandom_range(64)) - 32));
      s.target    = drift_point;
      s.measured  = DATA_W'(drift_point + (int'($urandom_range(600)) - 300));
    end else if (pick < 60) begin
      s.target   = corner_value();
      s.measured = corner_value();
    end else begin
      s = $urandom;
    end
    return s;
  endfunction

  // Presents one item, with random idle cycles ahead of it, and waits until
  // the block takes it.
  task automatic send_sample(sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  task automatic send_random(int count);
    for (int n = 0; n < count; n++) send_sample(random_sample());
    sample_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Gain registers take the low bits; the rest of the word is noise.
  function automatic logic [DATA_W-1:0] pad_gain(logic [GAIN_W-1:0] g);
    logic [DATA_W-1:0] d;
    d = DATA_W'($urandom);
    d[GAIN_W-1:0] = g;
    return d;
  endfunction

  task automatic program_regs(cfg_regs_t c);
    write_reg(REG_PROP_GAIN, pad_gain(c.prop_gain));
    write_reg(REG_INTEG_GAIN, pad_gain(c.integ_gain));
    write_reg(REG_DERIV_GAIN, pad_gain(c.deriv_gain));
    write_reg(REG_OUT_MIN, c.out_min);
    write_reg(REG_OUT_MAX, c.out_max);
    // Writes to unused indexes must leave every register alone.
    for (int i = int'(REG_OUT_MAX) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), DATA_W'($urandom));
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_idling(idle_mode_e m);
    case (m)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 72; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 72; end
      default:       begin send_idle_pct = 27; recv_stall_pct = 27; end
    endcase
  endtask

  // Register settings per phase: defaults, zero and full gains over the full
  // range, inverted limits, unit gains, equal limits, pure noise, gains 0-15.
  function automatic cfg_regs_t phase_config(int p);
    cfg_regs_t c;
    logic [63:0] noise;
    c.prop_gain  = GAIN_W'($urandom_range(15));
    c.integ_gain = GAIN_W'($urandom_range(15));
    c.deriv_gain = GAIN_W'($urandom_range(15));
    c.out_min    = -16'sd4000;
    c.out_max    = 16'sd4000;
    case (p)
      0: begin
        c.prop_gain  = PROP_GAIN_RST;
        c.integ_gain = INTEG_GAIN_RST;
        c.deriv_gain = DERIV_GAIN_RST;
        c.out_min    = OUT_MIN_RST;
        c.out_max    = OUT_MAX_RST;
      end
      1: begin
        c.prop_gain  = '0;
        c.integ_gain = '0;
        c.deriv_gain = '0;
        c.out_min    = 16'sh8000;
        c.out_max    = 16'sh7fff;
      end
      2: begin
        c.prop_gain  = '1;
        c.integ_gain = '1;
        c.deriv_gain = '1;
        c.out_min    = 16'sh8000;
        c.out_max    = 16'sh7fff;
      end
      3: begin
        c.out_min = 16'sd500;
        c.out_max = -16'sd500;
      end
      4: begin
        c.prop_gain  = 10'd1;
        c.integ_gain = 10'd1;
        c.deriv_gain = 10'd1;
        c.out_min    = 16'sh8000;
        c.out_max    = 16'sh7fff;
      end
      5: begin
        c.out_min = DATA_W'($urandom);
        c.out_max = c.out_min;
      end
      6: begin
        noise = {$urandom, $urandom};
        c     = noise[$bits(cfg_regs_t)-1:0];
      end
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    cfg_regs_t c;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed run on the reset settings: each integral step with its guard
    // met and not met, truncation of small steps, and wrapping errors.
    send_sample(pt(0, 0));
    send_sample(pt(0, 50));
    send_sample(pt(100, 0));
    send_sample(pt(150, 100));
    send_sample(pt(-10, 0));
    send_sample(pt(0, 3));
    send_sample(pt(0, 40));
    send_sample(pt(0, 20));
    send_sample(pt(32767, 0));
    send_sample(pt(32767, 0));
    send_sample(pt(1000, 0));
    send_sample(pt(10, 0));
    send_sample(pt(5, 0));
    send_sample(pt(32767, -32768));
    send_sample(pt(-32768, 32767));
    send_sample(pt(-32768, 0));
    send_sample(pt(0, -32768));
    send_sample(pt(32767, 32767));
    send_sample(pt(-32768, -32768));
    send_sample(pt(-1, 0));
    send_sample(pt(0, 32767));
    send_sample(pt(32767, 1));
    sample_valid <= 1'b0;

    // Random phases, each with its own register setting and idling.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      c = phase_config(p);
      program_regs(c);
      set_idling(idle_mode_e'(p % 4));
      send_random(RANDOM_PER_PHASE);
    end

    // The receiver holds off for a long stretch while items keep coming.
    wait_idle();
    c = phase_config(RANDOM_PHASES);
    program_regs(c);
    set_idling(IDLE_NONE);
    hold_req <= 1'b1;
    send_random(PRESSURE_ITEMS);

    wait_idle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
